// ----- hdl/stl_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// stl_pkg
// Shared widths, types and codes for the script token lexer.
// -----------------------------------------------------------------------------
package stl_pkg;

   localparam int LINE_WIDTH   = 24;
   localparam int COLUMN_WIDTH = 16;
   localparam int TAB_WIDTH    = 4;
   localparam int BYTE_WIDTH   = 8;
   localparam int KIND_WIDTH   = 2;
   localparam int SLOT_COUNT   = 3;

   localparam int QUEUE_DEPTH  = 4;
   localparam int PTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic [LINE_WIDTH-1:0]   line_type;
   typedef logic [COLUMN_WIDTH-1:0] column_type;
   typedef logic [KIND_WIDTH-1:0]   kind_type;
   typedef logic [BYTE_WIDTH-1:0]   byte_type;
   typedef logic [TAB_WIDTH-1:0]    tab_type;

   localparam kind_type KIND_BYTE = 2'd0;
   localparam kind_type KIND_END  = 2'd1;
   localparam kind_type KIND_MARK = 2'd2;

   localparam tab_type TAB_EXTRA_RESET = 4'd3;

   // one result
   typedef struct packed {
      kind_type   kind;
      byte_type   value;
      line_type   line;
      column_type column;
   } slot_type;

   // all results caused by one input byte; count is 1 to 3
   typedef struct packed {
      logic [1:0]               count;
      slot_type [SLOT_COUNT-1:0] slot;
   } packet_type;

   // front to queue
   typedef struct packed {
      logic       push;
      packet_type packet;
   } push_type;

   // queue to back
   typedef struct packed {
      logic       valid;
      packet_type packet;
   } head_type;

endpackage

`default_nettype wire

// ----- hdl/stl_front.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// stl_front
// Lexer state machine: classifies each byte and builds its result packet.
// -----------------------------------------------------------------------------
module stl_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire stl_pkg::byte_type     req_ch,
   input  wire logic                  queue_full,
   input  wire logic                  csr_valid,
   input  wire stl_pkg::tab_type      csr_tab_extra,
   output stl_pkg::push_type          push_out
);

   localparam logic [2:0] MODE_IDLE     = 3'd0;
   localparam logic [2:0] MODE_QUOTED   = 3'd1;
   localparam logic [2:0] MODE_ESCAPE   = 3'd2;
   localparam logic [2:0] MODE_UNQUOTED = 3'd3;
   localparam logic [2:0] MODE_COMMENT  = 3'd4;

   localparam stl_pkg::byte_type CH_NUL    = 8'h00;
   localparam stl_pkg::byte_type CH_TAB    = 8'h09;
   localparam stl_pkg::byte_type CH_NL     = 8'h0A;
   localparam stl_pkg::byte_type CH_CR     = 8'h0D;
   localparam stl_pkg::byte_type CH_SPACE  = 8'h20;
   localparam stl_pkg::byte_type CH_QUOTE  = 8'h22;
   localparam stl_pkg::byte_type CH_HASH   = 8'h23;
   localparam stl_pkg::byte_type CH_LT     = 8'h3C;
   localparam stl_pkg::byte_type CH_EQ     = 8'h3D;
   localparam stl_pkg::byte_type CH_GT     = 8'h3E;
   localparam stl_pkg::byte_type CH_BSLASH = 8'h5C;
   localparam stl_pkg::byte_type CH_LBRACE = 8'h7B;
   localparam stl_pkg::byte_type CH_RBRACE = 8'h7D;

   function automatic logic is_endline(input stl_pkg::byte_type c);
      return (c == CH_NL) || (c == CH_CR) || (c == CH_NUL);
   endfunction

   function automatic logic is_marker(input stl_pkg::byte_type c);
      return (c == CH_EQ) || (c == CH_GT) || (c == CH_LT) ||
             (c == CH_RBRACE) || (c == CH_LBRACE);
   endfunction

   function automatic logic is_blank(input stl_pkg::byte_type c);
      return (c == CH_TAB) || (c == CH_SPACE) || is_endline(c);
   endfunction

   function automatic logic is_delim(input stl_pkg::byte_type c);
      return is_blank(c) || is_marker(c) || (c == CH_HASH) || (c == CH_QUOTE);
   endfunction

   function automatic stl_pkg::column_type col_sat(input stl_pkg::column_type c,
                                                   input logic [4:0] amt);
      logic [stl_pkg::COLUMN_WIDTH:0] sum;
      sum = {1'b0, c} + {{(stl_pkg::COLUMN_WIDTH-4){1'b0}}, amt};
      return sum[stl_pkg::COLUMN_WIDTH] ? '1 : sum[stl_pkg::COLUMN_WIDTH-1:0];
   endfunction

   function automatic stl_pkg::slot_type mk_slot(input stl_pkg::kind_type k,
                                                 input stl_pkg::byte_type v,
                                                 input stl_pkg::line_type l,
                                                 input stl_pkg::column_type c);
      stl_pkg::slot_type s;
      s.kind   = k;
      s.value  = v;
      s.line   = l;
      s.column = c;
      return s;
   endfunction

   logic [2:0]           mode_ff, mode_in;
   stl_pkg::line_type    line_ff, line_in;
   stl_pkg::column_type  col_ff, col_in;
   stl_pkg::tab_type     tab_ff;

   logic                 accept;
   stl_pkg::line_type    line_inc;
   stl_pkg::column_type  col_p1;

   // effect of the byte when handled in idle mode from the current position
   logic [2:0]           idle_mode;
   stl_pkg::line_type    idle_line;
   stl_pkg::column_type  idle_col;
   logic                 idle_emit;
   stl_pkg::slot_type    idle_slot;

   stl_pkg::packet_type  pkt;

   assign accept   = req_valid && !queue_full;
   assign line_inc = (line_ff == '1) ? line_ff : line_ff + stl_pkg::LINE_WIDTH'(1);
   assign col_p1   = col_sat(col_ff, 5'd1);

   always_comb begin
      idle_mode = MODE_IDLE;
      idle_line = line_ff;
      idle_col  = col_p1;
      idle_emit = 1'b0;
      idle_slot = mk_slot(stl_pkg::KIND_BYTE, req_ch, line_ff, col_p1);
      if (req_ch == CH_QUOTE) begin
         idle_emit = 1'b1;
         idle_mode = MODE_QUOTED;
      end else if (req_ch == CH_HASH) begin
         idle_mode = MODE_COMMENT;
      end else if (is_marker(req_ch)) begin
         idle_emit = 1'b1;
         idle_slot.kind = stl_pkg::KIND_MARK;
      end else if (is_blank(req_ch)) begin
         if (req_ch == CH_NL) begin
            idle_line = line_inc;
            idle_col  = col_sat('0, 5'd1);
         end else if (req_ch == CH_TAB) begin
            idle_col = col_sat(col_ff, {1'b0, tab_ff} + 5'd1);
         end
      end else begin
         idle_emit = 1'b1;
         idle_mode = MODE_UNQUOTED;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      pkt        = '0;
      unique case (mode_ff)
         MODE_QUOTED: begin
            if (req_ch == CH_BSLASH) begin
               col_in      = col_p1;
               pkt.count   = 2'd1;
               pkt.slot[0] = mk_slot(stl_pkg::KIND_BYTE, req_ch, line_ff, col_p1);
               mode_in     = MODE_ESCAPE;
            end else if (req_ch == CH_QUOTE) begin
               col_in      = col_p1;
               pkt.count   = 2'd2;
               pkt.slot[0] = mk_slot(stl_pkg::KIND_BYTE, req_ch, line_ff, col_p1);
               pkt.slot[1] = mk_slot(stl_pkg::KIND_END, '0, line_ff, col_p1);
               mode_in     = MODE_IDLE;
            end else if (is_endline(req_ch)) begin
               // close the open quote, then handle the byte as idle
               pkt.count   = 2'd2;
               pkt.slot[0] = mk_slot(stl_pkg::KIND_BYTE, CH_QUOTE, line_ff, col_ff);
               pkt.slot[1] = mk_slot(stl_pkg::KIND_END, '0, line_ff, col_ff);
               mode_in     = idle_mode;
               line_in     = idle_line;
               col_in      = idle_col;
            end else begin
               col_in      = col_p1;
               pkt.count   = 2'd1;
               pkt.slot[0] = mk_slot(stl_pkg::KIND_BYTE, req_ch, line_ff, col_p1);
            end
         end
         MODE_ESCAPE: begin
            if (is_endline(req_ch)) begin
               pkt.count   = 2'd3;
               pkt.slot[0] = mk_slot(stl_pkg::KIND_BYTE, CH_QUOTE, line_ff, col_ff);
               pkt.slot[1] = mk_slot(stl_pkg::KIND_BYTE, CH_QUOTE, line_ff, col_ff);
               pkt.slot[2] = mk_slot(stl_pkg::KIND_END, '0, line_ff, col_ff);
               mode_in     = idle_mode;
               line_in     = idle_line;
               col_in      = idle_col;
            end else begin
               col_in      = col_p1;
               pkt.count   = 2'd1;
               pkt.slot[0] = mk_slot(stl_pkg::KIND_BYTE, req_ch, line_ff, col_p1);
               mode_in     = MODE_QUOTED;
            end
         end
         MODE_UNQUOTED: begin
            if (is_delim(req_ch)) begin
               pkt.count   = idle_emit ? 2'd2 : 2'd1;
               pkt.slot[0] = mk_slot(stl_pkg::KIND_END, '0, line_ff, col_ff);
               pkt.slot[1] = idle_slot;
               mode_in     = idle_mode;
               line_in     = idle_line;
               col_in      = idle_col;
            end else begin
               col_in      = col_p1;
               pkt.count   = 2'd1;
               pkt.slot[0] = mk_slot(stl_pkg::KIND_BYTE, req_ch, line_ff, col_p1);
            end
         end
         MODE_COMMENT: begin
            col_in = col_p1;
            if (is_endline(req_ch)) begin
               mode_in = MODE_IDLE;
               if (req_ch == CH_NL) begin
                  line_in = line_inc;
                  col_in  = col_sat('0, 5'd1);
               end
            end
         end
         default: begin
            pkt.count   = idle_emit ? 2'd1 : 2'd0;
            pkt.slot[0] = idle_slot;
            mode_in     = idle_mode;
            line_in     = idle_line;
            col_in      = idle_col;
         end
      endcase
   end

   assign push_out.push   = accept && (pkt.count != 2'd0);
   assign push_out.packet = pkt;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= stl_pkg::LINE_WIDTH'(1);
         col_ff  <= '0;
         tab_ff  <= stl_pkg::TAB_EXTRA_RESET;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            line_ff <= line_in;
            col_ff  <= col_in;
         end
         if (csr_valid) begin
            tab_ff <= csr_tab_extra;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/stl_queue.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// stl_queue
// Short packet queue between the lexer front and the result serialiser.
// -----------------------------------------------------------------------------
module stl_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stl_pkg::push_type push_in,
   input  wire logic              pop,
   output logic                   full,
   output stl_pkg::head_type      head
);

   stl_pkg::packet_type                entry_ff [stl_pkg::QUEUE_DEPTH];
   logic [stl_pkg::PTR_WIDTH-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [stl_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                               do_pop;

   assign full        = (count_ff == stl_pkg::COUNT_WIDTH'(stl_pkg::QUEUE_DEPTH));
   assign head.valid  = (count_ff != '0);
   assign head.packet = entry_ff[rd_ptr_ff];
   assign do_pop      = pop && head.valid;

   always_comb begin
      count_in = count_ff;
      if (push_in.push && !do_pop) begin
         count_in = count_ff + stl_pkg::COUNT_WIDTH'(1);
      end else if (!push_in.push && do_pop) begin
         count_in = count_ff - stl_pkg::COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.packet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_in.push) begin
            wr_ptr_ff <= wr_ptr_ff + stl_pkg::PTR_WIDTH'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + stl_pkg::PTR_WIDTH'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/stl_back.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// stl_back
// Result serialiser: walks the slots of the head packet into the output register.
// -----------------------------------------------------------------------------
module stl_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stl_pkg::head_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output stl_pkg::kind_type      rsp_kind,
   output stl_pkg::byte_type      rsp_byte_value,
   output stl_pkg::line_type      rsp_line_no,
   output stl_pkg::column_type    rsp_column_no,
   output logic                   rsp_last
);

   logic [1:0]          idx_ff;
   logic                valid_ff;
   stl_pkg::slot_type   slot_ff, cur_slot;
   logic                last_ff, cur_last, load;

   always_comb begin
      case (idx_ff)
         2'd1:    cur_slot = head.packet.slot[1];
         2'd2:    cur_slot = head.packet.slot[2];
         default: cur_slot = head.packet.slot[0];
      endcase
   end

   assign cur_last = (idx_ff == head.packet.count - 2'd1);
   assign load     = !valid_ff || !rsp_stall;
   assign pop      = load && head.valid && cur_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= head.valid;
         if (head.valid) begin
            idx_ff <= cur_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= cur_slot;
         last_ff <= cur_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = slot_ff.kind;
   assign rsp_byte_value = slot_ff.value;
   assign rsp_line_no    = slot_ff.line;
   assign rsp_column_no  = slot_ff.column;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ----- hdl/script_token_lexer.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// script_token_lexer
// Byte-serial lexer for key/value script text with line and column tracking.
// -----------------------------------------------------------------------------
// Usage:
//   req_ channel: one source byte per transaction (req_ch), taken at an edge
//   with req_valid high and req_stall low. A zero byte counts as blank and
//   end of line; lexing carries on with later bytes.
//   rsp_ channel: zero to three result transactions per byte (content byte,
//   end of token, marker), each with the line and column at that point;
//   rsp_last marks the final result of a byte.
//   csr_ channel: writes tab_extra (csr_tab_extra); csr_ready is always high.
//   Write it only while the block is idle.
// Flow: one byte is taken every cycle while the queue has room; its packet
//   is written to the packet queue and each result then passes through the
//   single output register of the serialiser before it is on rsp_. A byte's
//   results leave that register one after another; the four-entry packet
//   queue absorbs such bursts first.
// Reset: lexer idle, line 1, column 0, tab_extra 3, queue and output empty.
// Receiver stall: the output holds; the queue fills and then stalls req_.
// -----------------------------------------------------------------------------
module script_token_lexer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire stl_pkg::byte_type    req_ch,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output stl_pkg::kind_type         rsp_kind,
   output stl_pkg::byte_type         rsp_byte_value,
   output stl_pkg::line_type         rsp_line_no,
   output stl_pkg::column_type       rsp_column_no,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire stl_pkg::tab_type     csr_tab_extra
);

   stl_pkg::push_type   push;
   stl_pkg::head_type   head;
   logic                queue_full;
   logic                pop;

   // hold the source whenever the queue cannot take another packet
   assign req_stall = queue_full;
   assign csr_ready = 1'b1;

   // front: lexer modes, line and column counters, packet build
   stl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ch        (req_ch),
      .queue_full    (queue_full),
      .csr_valid     (csr_valid),
      .csr_tab_extra (csr_tab_extra),
      .push_out      (push)
   );

   // decouple the two sides; bytes with no result push nothing
   stl_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (queue_full),
      .head    (head)
   );

   // back: serialise each packet, advance slot by slot, drop it after the last
   stl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_line_no    (rsp_line_no),
      .rsp_column_no  (rsp_column_no),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ----- tb/sv/script_token_lexer_test.sv -----
// -----------------------------------------------------------------------------
// script_token_lexer_test
// Self-checking bench for the script token lexer. Bytes are pushed through
// the req_ channel in bursts while the rsp_ side stalls on its own pattern.
// Each accepted byte is lexed by a bench-side copy of the lexer state, and
// every result transaction is checked against the oldest predicted one.
// Directed cases, tab_extra settings, a long receiver hold-off and random
// script text are run in turn.
// -----------------------------------------------------------------------------
module script_token_lexer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import stl_pkg::*;

   // Timing and run length
   localparam int      RESET_CYCLES  = 9;
   localparam int      SETTLE_CYCLES = 8;       // a byte with no result may still be in flight
   localparam int      DRAIN_LIMIT   = 20000;   // cycles allowed for results to come out
   localparam int      RANDOM_ITEMS  = 90;
   localparam int      WRITE_EVERY   = 60;      // random bytes between tab_extra changes
   localparam int      HOLD_CYCLES   = 200;
   localparam realtime RUN_LIMIT_NS  = 10_000_000.0;

   localparam longint unsigned COLUMN_MAX = (64'd1 << COLUMN_WIDTH) - 1;
   localparam line_type        LINE_TOP   = {LINE_WIDTH{1'b1}};

   // Source characters the lexer treats specially
   localparam byte_type CH_NUL    = 8'h00;
   localparam byte_type CH_TAB    = 8'h09;
   localparam byte_type CH_NL     = 8'h0A;
   localparam byte_type CH_CR     = 8'h0D;
   localparam byte_type CH_SPACE  = 8'h20;
   localparam byte_type CH_QUOTE  = 8'h22;
   localparam byte_type CH_HASH   = 8'h23;
   localparam byte_type CH_LT     = 8'h3C;
   localparam byte_type CH_EQ     = 8'h3D;
   localparam byte_type CH_GT     = 8'h3E;
   localparam byte_type CH_BSLASH = 8'h5C;
   localparam byte_type CH_LBRACE = 8'h7B;
   localparam byte_type CH_RBRACE = 8'h7D;

   typedef enum logic [2:0] {
      LX_IDLE     = 3'd0,
      LX_QUOTED   = 3'd1,
      LX_ESCAPE   = 3'd2,
      LX_UNQUOTED = 3'd3,
      LX_COMMENT  = 3'd4
   } lex_state_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   // One result transaction as seen on rsp_
   typedef struct {
      kind_type   kind;
      byte_type   value;
      line_type   line_no;
      column_type column_no;
      logic       last;
   } lexeme_type;

   // DUT ports
   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   byte_type   req_ch;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   kind_type   rsp_kind;
   byte_type   rsp_byte_value;
   line_type   rsp_line_no;
   column_type rsp_column_no;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   tab_type    csr_tab_extra;

   // Bench-side lexer state, advanced on every accepted byte
   lex_state_type lex_state;
   line_type      line_now;
   column_type    col_now;
   tab_type       tab_extra_now;
   lexeme_type    step_burst[$];         // results of the byte being lexed
   lexeme_type    token_stream_due[$];   // results predicted but not yet seen

   // Sender shaping
   int unsigned burst_left = 0;
   bit          gaps_on    = 1'b1;

   // Receiver hold-off request: the test bumps the sequence number, the
   // receiver process picks the length up and counts it down itself
   int unsigned    hold_off_len   = 0;
   int unsigned    hold_off_seq   = 0;
   int unsigned    hold_off_taken = 0;
   int unsigned    hold_off_left  = 0;
   stall_mode_type stall_mode     = STALL_NONE;
   int unsigned    stall_seg_left = 0;

   // Tallies
   int unsigned error_count    = 0;
   int unsigned bytes_lexed    = 0;
   int unsigned results_seen   = 0;
   int unsigned csr_writes     = 0;
   int unsigned input_held     = 0;
   lexeme_type  got_result;
   lexeme_type  want_result;

   script_token_lexer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_line_no    (rsp_line_no),
      .rsp_column_no  (rsp_column_no),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_tab_extra  (csr_tab_extra)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Lexer prediction
   // -------------------------------------------------------------------------
   function automatic bit is_endline(input byte_type c);
      return c == CH_NL || c == CH_CR || c == CH_NUL;
   endfunction

   function automatic bit is_marker(input byte_type c);
      return c == CH_EQ || c == CH_GT || c == CH_LT || c == CH_RBRACE || c == CH_LBRACE;
   endfunction

   function automatic bit is_blank(input byte_type c);
      return c == CH_TAB || c == CH_SPACE || is_endline(c);
   endfunction

   function automatic bit is_delim(input byte_type c);
      return is_blank(c) || is_marker(c) || c == CH_HASH || c == CH_QUOTE;
   endfunction

   // Advance the column, pinning it at its top value
   function automatic void col_bump(input int unsigned n);
      longint unsigned sum;
      sum = 64'(col_now);
      sum += 64'(n);
      if (sum > COLUMN_MAX) col_now = '1;
      else col_now = column_type'(sum);
   endfunction

   function automatic void line_break();
      if (line_now != LINE_TOP) line_now++;
      col_now = '0;
   endfunction

   // Queue one result with the position as it stands now; three at most per byte
   function automatic void put(input kind_type k, input byte_type v);
      lexeme_type r;
      if (step_burst.size() >= SLOT_COUNT) return;
      r.kind      = k;
      r.value     = v;
      r.line_no   = line_now;
      r.column_no = col_now;
      r.last      = 1'b0;
      step_burst.insert(step_burst.size(), r);
   endfunction

   // A byte seen from the idle state, either fresh or handed back by a mode
   function automatic void lex_idle(input byte_type c);
      if (c == CH_QUOTE) begin
         col_bump(1);
         put(KIND_BYTE, c);
         lex_state = LX_QUOTED;
      end else if (c == CH_HASH) begin
         col_bump(1);
         lex_state = LX_COMMENT;
      end else if (is_marker(c)) begin
         col_bump(1);
         put(KIND_MARK, c);
      end else if (is_blank(c)) begin
         if (c == CH_NL) line_break();
         else if (c == CH_TAB) col_bump(32'(tab_extra_now));
         col_bump(1);
      end else begin
         col_bump(1);
         put(KIND_BYTE, c);
         lex_state = LX_UNQUOTED;
      end
   endfunction

   function automatic void lex_byte(input byte_type c);
      step_burst.delete();
      case (lex_state)
         LX_QUOTED: begin
            if (c == CH_BSLASH) begin
               col_bump(1);
               put(KIND_BYTE, c);
               lex_state = LX_ESCAPE;
            end else if (c == CH_QUOTE) begin
               col_bump(1);
               put(KIND_BYTE, c);
               put(KIND_END, 8'h00);
               lex_state = LX_IDLE;
            end else if (is_endline(c)) begin
               // close the open quote for the writer, then treat the byte as blank
               put(KIND_BYTE, CH_QUOTE);
               put(KIND_END, 8'h00);
               lex_state = LX_IDLE;
               lex_idle(c);
            end else begin
               col_bump(1);
               put(KIND_BYTE, c);
            end
         end
         LX_ESCAPE: begin
            if (is_endline(c)) begin
               put(KIND_BYTE, CH_QUOTE);
               put(KIND_BYTE, CH_QUOTE);
               put(KIND_END, 8'h00);
               lex_state = LX_IDLE;
               lex_idle(c);
            end else begin
               col_bump(1);
               put(KIND_BYTE, c);
               lex_state = LX_QUOTED;
            end
         end
         LX_UNQUOTED: begin
            if (is_delim(c)) begin
               put(KIND_END, 8'h00);
               lex_state = LX_IDLE;
               lex_idle(c);
            end else begin
               col_bump(1);
               put(KIND_BYTE, c);
            end
         end
         LX_COMMENT: begin
            if (is_endline(c)) begin
               if (c == CH_NL) line_break();
               lex_state = LX_IDLE;
            end
            col_bump(1);
         end
         default: begin
            lex_state = LX_IDLE;
            lex_idle(c);
         end
      endcase
      if (step_burst.size() > 0) step_burst[step_burst.size() - 1].last = 1'b1;
      foreach (step_burst[i]) token_stream_due.insert(token_stream_due.size(), step_burst[i]);
   endfunction

   function automatic void note_error(input string what);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", what);
   endfunction

   // -------------------------------------------------------------------------
   // Result side: check every accepted transaction, count input back-pressure
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) input_held++;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_result = '{rsp_kind, rsp_byte_value, rsp_line_no, rsp_column_no, rsp_last};
         results_seen++;
         if (token_stream_due.size() == 0) begin
            note_error($sformatf("result %0d arrived with none due: kind=%0d byte=%02h",
                                 results_seen, got_result.kind, got_result.value));
         end else begin
            want_result = token_stream_due.pop_front();
            if (got_result.kind !== want_result.kind ||
                got_result.value !== want_result.value ||
                got_result.line_no !== want_result.line_no ||
                got_result.column_no !== want_result.column_no ||
                got_result.last !== want_result.last) begin
               note_error($sformatf({"result %0d expected kind=%0d byte=%02h line=%0d col=%0d ",
                                     "last=%0d, got kind=%0d byte=%02h line=%0d col=%0d last=%0d"},
                                    results_seen, want_result.kind, want_result.value,
                                    want_result.line_no, want_result.column_no,
                                    want_result.last, got_result.kind, got_result.value,
                                    got_result.line_no, got_result.column_no,
                                    got_result.last));
            end
         end
      end
   end

   // Receiver: a long hold-off when asked, otherwise segments of no, light
   // or heavy stalling of random length
   always @(negedge clock) begin
      if (hold_off_seq != hold_off_taken) begin
         hold_off_taken = hold_off_seq;
         hold_off_left  = hold_off_len;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_seg_left == 0) begin
            stall_mode     = stall_mode_type'($urandom_range(0, 2));
            stall_seg_left = $urandom_range(8, 60);
         end
         stall_seg_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:     rsp_stall <= ($urandom_range(0, 2) != 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks: all of them start and finish just after a falling edge
   // -------------------------------------------------------------------------
   task automatic idle_for(input int unsigned n);
      if (n == 0) return;
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Offer one byte and hold it until the block takes it
   task automatic send_byte(input byte_type c);
      req_valid <= 1'b1;
      req_ch    <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lex_byte(c);
      bytes_lexed++;
      @(negedge clock);
   endtask

   // Bursts of random length, with a random gap ahead of each when gaps are on
   task automatic offer(input byte_type c);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on) idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      burst_left--;
      send_byte(c);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) offer(byte_type'(s[i]));
   endtask

   // Drop valid and wait for every predicted result, then let the pipe settle
   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (token_stream_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (token_stream_due.size() != 0) begin
         note_error($sformatf("%0d predicted results never arrived", token_stream_due.size()));
         token_stream_due.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      burst_left = 0;
   endtask

   // Only call with the block drained
   task automatic write_tab_extra(input tab_type v);
      csr_valid     <= 1'b1;
      csr_tab_extra <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tab_extra_now = v;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Random text pieces
   // -------------------------------------------------------------------------
   function automatic byte_type word_char();
      case ($urandom_range(0, 3))
         0:       return byte_type'("0" + $urandom_range(0, 9));
         1:       return byte_type'("_");
         default: return byte_type'("a" + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic byte_type pick_marker();
      case ($urandom_range(0, 4))
         0:       return CH_EQ;
         1:       return CH_LT;
         2:       return CH_GT;
         3:       return CH_LBRACE;
         default: return CH_RBRACE;
      endcase
   endfunction

   function automatic byte_type pick_line_end();
      case ($urandom_range(0, 5))
         0:       return CH_CR;
         1:       return CH_NUL;
         default: return CH_NL;
      endcase
   endfunction

   function automatic byte_type pick_blank();
      case ($urandom_range(0, 4))
         0:       return CH_TAB;
         1:       return CH_NL;
         2:       return CH_CR;
         3:       return CH_NUL;
         default: return CH_SPACE;
      endcase
   endfunction

   task automatic offer_word();
      repeat ($urandom_range(1, 6)) offer(word_char());
   endtask

   // Quoted string with escapes; now and then left open at end of line
   task automatic offer_quoted();
      byte_type b;
      offer(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 5) == 0) begin
            offer(CH_BSLASH);
            offer(byte_type'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 7) == 0) b = byte_type'($urandom_range(128, 255));
            else b = byte_type'($urandom_range(32, 126));
            if (b == CH_QUOTE || b == CH_BSLASH) b = byte_type'("q");
            offer(b);
         end
      end
      if ($urandom_range(0, 3) == 0) offer(pick_line_end());
      else offer(CH_QUOTE);
   endtask

   task automatic offer_fragment();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
         // key = value, mostly with an equals sign
         offer_word();
         if ($urandom_range(0, 1)) offer(CH_SPACE);
         offer(($urandom_range(0, 3) == 0) ? pick_marker() : CH_EQ);
         if ($urandom_range(0, 1)) offer(CH_SPACE);
         case ($urandom_range(0, 3))
            0:       offer_quoted();
            1:       offer(pick_marker());
            default: offer_word();
         endcase
         offer(($urandom_range(0, 2) == 0) ? pick_blank() : CH_NL);
      end else if (pick <= 5) begin
         offer_quoted();
      end else if (pick == 6) begin
         offer(CH_HASH);
         repeat ($urandom_range(0, 8)) offer(byte_type'($urandom_range(32, 255)));
         offer(pick_line_end());
      end else if (pick == 7) begin
         repeat ($urandom_range(1, 4)) offer(($urandom_range(0, 1)) ? pick_marker() : pick_blank());
      end else begin
         // raw noise over the whole byte range
         repeat ($urandom_range(1, 6)) offer(byte_type'($urandom_range(0, 255)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Word ended by a marker, a top-bit byte ended by a brace, all markers, tab
   task automatic test_words_and_markers();
      send_text("a=");
      offer(8'hFF);
      send_text("{}<>\t");
   endtask

   // Escaped quote, escape at end of line, quote left open at a carriage return
   task automatic test_quotes_and_escapes();
      send_text("\"q\\\"\"");
      send_text("\"a\\\n");
      send_text("y\"b");
      offer(CH_CR);
   endtask

   // Comment opened straight after a word, ended by zero, by newline; zero in idle
   task automatic test_comment_endings();
      send_text("x#c");
      offer(CH_NUL);
      send_text("#\n");
      offer(CH_NUL);
      offer(CH_CR);
   endtask

   // Tabs at both extremes of tab_extra and one value in between
   task automatic test_tab_extra_settings();
      tab_type v;
      for (int i = 0; i < 3; i++) begin
         v = (i == 0) ? tab_type'(0) : (i == 1) ? tab_type'(15) : tab_type'($urandom_range(1, 14));
         drain_results();
         write_tab_extra(v);
         send_text("\tk\t=\t\"t\"\t\n");
      end
   endtask

   // Hold the receiver off for a long stretch while bytes keep coming
   // back to back, so the queue fills and req_stall rises; then pause
   // the sender until every result is out
   task automatic test_receiver_hold_off();
      drain_results();
      gaps_on      = 1'b0;
      hold_off_len = HOLD_CYCLES;
      hold_off_seq++;
      send_text("k = {\n a = \"v\" b = c\n}\nx=y z=w <>\n");
      drain_results();
      gaps_on = 1'b1;
   endtask

   // Script-like text mixed with noise, with tab_extra changed now and then
   task automatic test_random_script();
      int unsigned first, next_write;
      first      = bytes_lexed;
      next_write = first + WRITE_EVERY;
      while (bytes_lexed - first < RANDOM_ITEMS) begin
         if (bytes_lexed >= next_write) begin
            drain_results();
            write_tab_extra(tab_type'($urandom_range(0, 15)));
            next_write += WRITE_EVERY;
         end
         // alternate stretches with and without sender gaps
         if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
         offer_fragment();
      end
      gaps_on = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_ch        = '0;
      csr_valid     = 1'b0;
      csr_tab_extra = '0;
      lex_state     = LX_IDLE;
      line_now      = line_type'(1);
      col_now       = '0;
      tab_extra_now = TAB_EXTRA_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_words_and_markers();
      test_quotes_and_escapes();
      test_comment_endings();
      test_tab_extra_settings();
      test_receiver_hold_off();
      test_random_script();

      // Wait out the tail; a stray result here still counts as an error
      drain_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("Lexed %0d bytes into %0d results over %0d tab_extra settings;",
               bytes_lexed, results_seen, csr_writes + 1);
      $display("input held back for %0d cycles, %0d errors.", input_held, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/stl_pkg.sv
hdl/stl_front.sv
hdl/stl_queue.sv
hdl/stl_back.sv
hdl/script_token_lexer.sv
tb/sv/script_token_lexer_test.sv
